FILE: hdl/sqtt_pkg.sv
// Shared types, character codes and helper functions for the query term tokenizer.
// Depends on nothing; used by search_query_term_tokenizer_core and sqtt_checker.
package sqtt_pkg;

  // Default query capacity in bytes
  localparam int QUERY_LEN_MAX_DEF = 4096;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // Quote kinds
  localparam logic [1:0] QK_NONE   = 2'd0;
  localparam logic [1:0] QK_SINGLE = 2'd1;
  localparam logic [1:0] QK_DOUBLE = 2'd2;

  // Scan phases
  typedef enum logic [2:0] {
    PH_SKIP1 = 3'd0,  // skip blanks, minus still allowed
    PH_SKIP2 = 3'd1,  // skip blanks after a minus
    PH_TERM  = 3'd2,  // inside a term
    PH_COLON = 3'd3,  // byte right after a colon
    PH_QUOTE = 3'd4   // byte right after a quote that followed a colon
  } phase_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [1:0] quote_code(input logic [7:0] c);
    logic [1:0] q;
    q = QK_NONE;
    if (c == CH_SQUOTE) q = QK_SINGLE;
    if (c == CH_DQUOTE) q = QK_DOUBLE;
    return q;
  endfunction

endpackage

FILE: hdl/search_query_term_tokenizer_core.sv
// Query term tokenizer: splits a byte stream into terms with optional prefix and sign.
// Depends on sqtt_pkg for phase type, character codes and helper functions.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | input     | in_valid/in_ready   | query_byte, last_byte
//  out_    | output    | out_valid/out_ready | term record or end marker (one per result)
//
// One byte per cycle while the skid register is empty. A transferred byte is held in the input
// register, and the scan logic forms its result combinationally, which the result register
// then loads (input register, then scan logic into the result register).
// The result side has a one-entry skid register, so a stalled result does not block
// the next byte until the skid is full as well.
// Reset (rst_n, synchronous) clears the scan state, byte position and both output slots.
// The final byte of every query yields exactly one result with end_of_query set.
module search_query_term_tokenizer_core #(
  parameter int QUERY_LEN_MAX = sqtt_pkg::QUERY_LEN_MAX_DEF,
  localparam int OW = $clog2(QUERY_LEN_MAX),
  localparam int LW = OW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_query_byte,
  input  logic          in_last_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_term_valid,
  output logic          out_include_term,
  output logic          out_has_prefix,
  output logic [OW-1:0] out_prefix_offset,
  output logic [LW-1:0] out_prefix_length,
  output logic [OW-1:0] out_term_offset,
  output logic [LW-1:0] out_term_length,
  output logic          out_end_of_query,
  output logic          out_too_long
);

  localparam int RW = 5 + 2 * OW + 2 * LW;
  localparam logic [LW-1:0] MAX_POS = LW'(QUERY_LEN_MAX);
  localparam logic [OW-1:0] MAX_IDX = OW'(QUERY_LEN_MAX - 1);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_fire;

  // Scan state
  sqtt_pkg::phase_t phase_r, phase_nxt;
  logic          inc_r, inc_nxt;
  logic [1:0]    qk_r, qk_nxt;
  logic [OW-1:0] tb_r, tb_nxt;
  logic [OW-1:0] pb_r, pb_nxt;
  logic [OW-1:0] pe_r, pe_nxt;
  logic          ps_r, ps_nxt;
  logic          filled_r, filled_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic          stop_r, stop_nxt;
  logic          ovf_r, ovf_nxt;

  // Result path
  logic          res_valid;
  logic [RW-1:0] res_data;
  logic          out_valid_r;
  logic [RW-1:0] out_data_r;
  logic          skid_valid_r;
  logic [RW-1:0] skid_data_r;
  logic          out_fire;

  assign s1_fire  = s1_valid_r && !skid_valid_r;
  assign in_ready = !s1_valid_r || s1_fire;
  assign out_fire = out_valid_r && out_ready;

  // Capture input byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_byte_r <= in_query_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Scan one byte: phase update, term finish and result forming
  always_comb begin
    logic [7:0]    c;
    logic          last;
    logic          blank;
    logic [1:0]    q;
    logic [LW-1:0] cur;
    logic [LW-1:0] pos_inc;
    logic [OW-1:0] idx;
    logic [OW-1:0] nidx;
    logic          fin;
    logic          clr;
    logic [LW-1:0] fin_end;
    logic          fin_eoq;
    logic          produce;
    logic          pre;
    logic [LW-1:0] tlen;
    logic [OW-1:0] p_off;
    logic [LW-1:0] p_len;

    c          = s1_byte_r;
    last       = s1_last_r;
    blank      = sqtt_pkg::is_blank(c);
    q          = sqtt_pkg::quote_code(c);
    phase_nxt  = phase_r;
    inc_nxt    = inc_r;
    qk_nxt     = qk_r;
    tb_nxt     = tb_r;
    pb_nxt     = pb_r;
    pe_nxt     = pe_r;
    ps_nxt     = ps_r;
    filled_nxt = filled_r;
    pos_nxt    = pos_r;
    stop_nxt   = stop_r;
    ovf_nxt    = ovf_r;
    fin        = 1'b0;
    clr        = 1'b0;
    fin_end    = '0;
    fin_eoq    = 1'b0;
    pos_inc    = pos_r + LW'(1);

    // Saturating byte position
    if (pos_r >= MAX_POS) begin
      cur = MAX_POS;
      idx = MAX_IDX;
    end else begin
      cur = pos_r;
      idx = pos_r[OW-1:0];
    end
    nidx = (pos_inc < MAX_POS) ? pos_inc[OW-1:0] : MAX_IDX;

    if (!stop_r) begin
      if (pos_r >= MAX_POS) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc;
      end

      if (c == sqtt_pkg::CH_NUL) begin
        // Zero byte ends the text; ignore the rest of the query
        stop_nxt = 1'b1;
        if (phase_r == sqtt_pkg::PH_TERM) begin
          fin     = 1'b1;
          fin_end = cur;
          fin_eoq = last;
        end else begin
          clr = 1'b1;
        end
      end else begin
        unique case (phase_r)
          sqtt_pkg::PH_SKIP1, sqtt_pkg::PH_SKIP2: begin
            if (!blank) begin
              if (phase_r == sqtt_pkg::PH_SKIP1 && c == sqtt_pkg::CH_MINUS) begin
                inc_nxt   = 1'b0;
                phase_nxt = sqtt_pkg::PH_SKIP2;
              end else if (q != sqtt_pkg::QK_NONE) begin
                qk_nxt     = q;
                tb_nxt     = nidx;
                filled_nxt = 1'b0;
                phase_nxt  = sqtt_pkg::PH_TERM;
              end else if (c == sqtt_pkg::CH_COLON) begin
                // Empty prefix right at term start
                tb_nxt     = idx;
                filled_nxt = 1'b0;
                pb_nxt     = idx;
                pe_nxt     = idx;
                ps_nxt     = 1'b1;
                phase_nxt  = sqtt_pkg::PH_COLON;
              end else begin
                tb_nxt     = idx;
                filled_nxt = 1'b1;
                phase_nxt  = sqtt_pkg::PH_TERM;
              end
            end
          end
          sqtt_pkg::PH_TERM: begin
            if ((qk_r == sqtt_pkg::QK_NONE && blank) ||
                (qk_r != sqtt_pkg::QK_NONE && q == qk_r)) begin
              fin     = 1'b1;
              fin_end = cur;
              fin_eoq = last;
            end else if (qk_r == sqtt_pkg::QK_NONE && c == sqtt_pkg::CH_COLON) begin
              // Current term becomes the prefix
              pb_nxt    = tb_r;
              pe_nxt    = idx;
              ps_nxt    = 1'b1;
              phase_nxt = sqtt_pkg::PH_COLON;
            end else begin
              filled_nxt = 1'b1;
            end
          end
          sqtt_pkg::PH_COLON: begin
            if (q != sqtt_pkg::QK_NONE) begin
              qk_nxt    = q;
              phase_nxt = sqtt_pkg::PH_QUOTE;
            end else begin
              tb_nxt     = idx;
              filled_nxt = 1'b1;
              phase_nxt  = sqtt_pkg::PH_TERM;
            end
          end
          default: begin
            // Byte after a quote following a colon: take it unchecked
            tb_nxt     = idx;
            filled_nxt = 1'b1;
            phase_nxt  = sqtt_pkg::PH_TERM;
          end
        endcase

        // Final byte closes whatever is open
        if (last && !fin) begin
          if (phase_nxt == sqtt_pkg::PH_TERM) begin
            fin     = 1'b1;
            fin_end = pos_nxt;
            fin_eoq = 1'b1;
          end else begin
            clr = 1'b1;
          end
        end
      end
    end

    // Form the term record from the state as it stands before clearing
    produce = fin && filled_nxt;
    pre     = ps_nxt && (pe_nxt > pb_nxt);
    tlen    = (fin_end > {1'b0, tb_nxt}) ? (fin_end - {1'b0, tb_nxt}) : LW'(1);
    p_off   = pre ? pb_nxt : '0;
    p_len   = pre ? ({1'b0, pe_nxt} - {1'b0, pb_nxt}) : '0;

    if (produce) begin
      res_data = {1'b1, inc_nxt, pre, p_off, p_len, tb_nxt, tlen, fin_eoq, ovf_nxt};
    end else begin
      res_data = {1'b0, 1'b0, 1'b0, {OW{1'b0}}, {LW{1'b0}}, {OW{1'b0}}, {LW{1'b0}},
                  1'b1, ovf_nxt};
    end
    res_valid = s1_fire && (produce || last);

    // Drop the term state after a finish or an end of text
    if (fin || clr) begin
      phase_nxt  = sqtt_pkg::PH_SKIP1;
      inc_nxt    = 1'b1;
      qk_nxt     = sqtt_pkg::QK_NONE;
      tb_nxt     = '0;
      pb_nxt     = '0;
      pe_nxt     = '0;
      ps_nxt     = 1'b0;
      filled_nxt = 1'b0;
    end
    // Final byte returns everything to reset values
    if (last) begin
      phase_nxt  = sqtt_pkg::PH_SKIP1;
      inc_nxt    = 1'b1;
      qk_nxt     = sqtt_pkg::QK_NONE;
      tb_nxt     = '0;
      pb_nxt     = '0;
      pe_nxt     = '0;
      ps_nxt     = 1'b0;
      filled_nxt = 1'b0;
      pos_nxt    = '0;
      stop_nxt   = 1'b0;
      ovf_nxt    = 1'b0;
    end
  end

  // Advance scan state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sqtt_pkg::PH_SKIP1;
      inc_r    <= 1'b1;
      qk_r     <= sqtt_pkg::QK_NONE;
      tb_r     <= '0;
      pb_r     <= '0;
      pe_r     <= '0;
      ps_r     <= 1'b0;
      filled_r <= 1'b0;
      pos_r    <= '0;
      stop_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (s1_fire) begin
      phase_r  <= phase_nxt;
      inc_r    <= inc_nxt;
      qk_r     <= qk_nxt;
      tb_r     <= tb_nxt;
      pb_r     <= pb_nxt;
      pe_r     <= pe_nxt;
      ps_r     <= ps_nxt;
      filled_r <= filled_nxt;
      pos_r    <= pos_nxt;
      stop_r   <= stop_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // Output register plus skid: hold a stalled result, park the next one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end
  end

  // Unpack the result register
  assign out_valid = out_valid_r;
  assign {out_term_valid, out_include_term, out_has_prefix, out_prefix_offset,
          out_prefix_length, out_term_offset, out_term_length, out_end_of_query,
          out_too_long} = out_data_r;

endmodule

FILE: hdl/sqtt_checker.sv
// Port-level checks for the query term tokenizer, bound to its top level.
// Depends on sqtt_pkg and search_query_term_tokenizer_core.
module sqtt_checker #(
  parameter int QUERY_LEN_MAX = sqtt_pkg::QUERY_LEN_MAX_DEF,
  localparam int OW = $clog2(QUERY_LEN_MAX),
  localparam int LW = OW + 1
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_term_valid,
  input logic          out_include_term,
  input logic          out_has_prefix,
  input logic [OW-1:0] out_prefix_offset,
  input logic [LW-1:0] out_prefix_length,
  input logic [OW-1:0] out_term_offset,
  input logic [LW-1:0] out_term_length,
  input logic          out_end_of_query
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_term_offset) &&
      $stable(out_term_length) && $stable(out_end_of_query))
    else $error("stalled result changed");

  // Bare end marker only at end of query and carries no sign
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_term_valid |-> out_end_of_query && !out_include_term &&
      !out_has_prefix && out_term_length == '0)
    else $error("bad end marker");

  // Term record is never empty
  a_term_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_term_valid |-> out_term_length != '0)
    else $error("empty term reported");

  // Prefix fields zero without prefix, nonzero length with it
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_prefix |-> out_prefix_offset == '0 && out_prefix_length == '0)
    else $error("prefix fields set without prefix");

  a_prefix_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_prefix |-> out_prefix_length != '0)
    else $error("empty prefix flagged");

endmodule

bind search_query_term_tokenizer_core sqtt_checker #(
  .QUERY_LEN_MAX(QUERY_LEN_MAX)
) u_sqtt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_term_valid   (out_term_valid),
  .out_include_term (out_include_term),
  .out_has_prefix   (out_has_prefix),
  .out_prefix_offset(out_prefix_offset),
  .out_prefix_length(out_prefix_length),
  .out_term_offset  (out_term_offset),
  .out_term_length  (out_term_length),
  .out_end_of_query (out_end_of_query)
);

FILE: sim/search_query_term_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for search_query_term_tokenizer_core: random and directed query bytes
// are scored against a behavioral tokenizer kept in the bench. Depends on sqtt_pkg and the core.
module search_query_term_tokenizer_core_tb;

  localparam int unsigned QLEN = sqtt_pkg::QUERY_LEN_MAX_DEF;
  localparam int OW = $clog2(QLEN);
  localparam int LW = OW + 1;
  localparam int IDLE_PCT = 16;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CALM_FROM = 300;
  localparam int CALM_TO = 520;
  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic          term_valid;
    logic          include_term;
    logic          has_prefix;
    logic [OW-1:0] prefix_offset;
    logic [LW-1:0] prefix_length;
    logic [OW-1:0] term_offset;
    logic [LW-1:0] term_length;
    logic          end_of_query;
    logic          too_long;
  } term_rec_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } byte_item_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [7:0]    in_query_byte = 8'h00;
  logic          in_last_byte = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_term_valid;
  logic          out_include_term;
  logic          out_has_prefix;
  logic [OW-1:0] out_prefix_offset;
  logic [LW-1:0] out_prefix_length;
  logic [OW-1:0] out_term_offset;
  logic [LW-1:0] out_term_length;
  logic          out_end_of_query;
  logic          out_too_long;

  byte_item_t  pending[$];
  logic [7:0]  qbuf[$];
  term_rec_t   term_q[$];
  logic        in_xfer = 1'b0;
  int          in_count = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // Tokenizer state tracked by the bench
  sqtt_pkg::phase_t tk_phase;
  logic        tk_include;
  logic [1:0]  tk_quote;
  int unsigned tk_term_begin, tk_pre_begin, tk_pre_end, tk_pos;
  logic        tk_pre_seen, tk_stopped, tk_overflow, tk_filled;

  search_query_term_tokenizer_core #(.QUERY_LEN_MAX(QLEN)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_query_byte(in_query_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_term_valid(out_term_valid), .out_include_term(out_include_term),
    .out_has_prefix(out_has_prefix), .out_prefix_offset(out_prefix_offset),
    .out_prefix_length(out_prefix_length), .out_term_offset(out_term_offset),
    .out_term_length(out_term_length), .out_end_of_query(out_end_of_query),
    .out_too_long(out_too_long)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm = (in_count >= CALM_FROM) && (in_count < CALM_TO);

  // ---------------------------------------------------------------- prediction

  function automatic logic blank_char(input logic [7:0] c);
    return (c == sqtt_pkg::CH_SPACE) || (c >= sqtt_pkg::CH_TAB && c <= sqtt_pkg::CH_CR);
  endfunction

  function automatic logic [1:0] quote_of(input logic [7:0] c);
    if (c == sqtt_pkg::CH_SQUOTE) return sqtt_pkg::QK_SINGLE;
    if (c == sqtt_pkg::CH_DQUOTE) return sqtt_pkg::QK_DOUBLE;
    return sqtt_pkg::QK_NONE;
  endfunction

  task automatic clear_term_state();
    tk_phase = sqtt_pkg::PH_SKIP1;
    tk_include = 1'b1;
    tk_quote = sqtt_pkg::QK_NONE;
    tk_term_begin = 0;
    tk_pre_begin = 0;
    tk_pre_end = 0;
    tk_pre_seen = 1'b0;
    tk_filled = 1'b0;
  endtask

  task automatic tok_reset();
    clear_term_state();
    tk_pos = 0;
    tk_stopped = 1'b0;
    tk_overflow = 1'b0;
  endtask

  task automatic open_term(input int unsigned at);
    tk_term_begin = at;
    tk_filled = 1'b0;
    tk_phase = sqtt_pkg::PH_TERM;
  endtask

  // Emit a record for the current term if it holds bytes, then drop the term
  task automatic close_term(input int unsigned stop, input logic eoq, output logic got,
                            output term_rec_t r);
    int unsigned len;
    logic pre;
    got = 1'b0;
    r = '0;
    if (tk_filled) begin
      len = (stop > tk_term_begin) ? stop - tk_term_begin : 1;
      pre = tk_pre_seen && (tk_pre_end > tk_pre_begin);
      r.term_valid = 1'b1;
      r.include_term = tk_include;
      r.has_prefix = pre;
      if (pre) begin
        r.prefix_offset = OW'(tk_pre_begin);
        r.prefix_length = LW'(tk_pre_end - tk_pre_begin);
      end
      r.term_offset = OW'(tk_term_begin);
      r.term_length = LW'(len);
      r.end_of_query = eoq;
      r.too_long = tk_overflow;
      got = 1'b1;
    end
    clear_term_state();
  endtask

  task automatic close_at_end(input int unsigned stop, input logic eoq, output logic got,
                              output term_rec_t r);
    got = 1'b0;
    r = '0;
    if (tk_phase == sqtt_pkg::PH_TERM) close_term(stop, eoq, got, r);
    else clear_term_state();
  endtask

  // One byte inside a term: a blank or the matching quote ends it, a bare colon makes a prefix
  task automatic term_char(input logic [7:0] c, input int unsigned cur, input int unsigned idx,
                           input logic last, output logic got, output term_rec_t r);
    got = 1'b0;
    r = '0;
    if ((tk_quote == sqtt_pkg::QK_NONE && blank_char(c)) ||
        (tk_quote != sqtt_pkg::QK_NONE && quote_of(c) == tk_quote)) begin
      close_term(cur, last, got, r);
    end else if (tk_quote == sqtt_pkg::QK_NONE && c == sqtt_pkg::CH_COLON) begin
      tk_pre_begin = tk_term_begin;
      tk_pre_end = idx;
      tk_pre_seen = 1'b1;
      tk_phase = sqtt_pkg::PH_COLON;
    end else begin
      tk_filled = 1'b1;
    end
  endtask

  task automatic tok_byte(input logic [7:0] c, input logic last, output logic got,
                          output term_rec_t r);
    int unsigned cur, idx, nidx;
    logic [1:0] q;
    got = 1'b0;
    r = '0;
    if (!tk_stopped) begin
      // Saturate the position once the query outgrows the capacity
      if (tk_pos >= QLEN) begin
        tk_overflow = 1'b1;
        cur = QLEN;
      end else begin
        cur = tk_pos;
        tk_pos++;
      end
      idx = (cur < QLEN) ? cur : QLEN - 1;
      nidx = (cur + 1 < QLEN) ? cur + 1 : QLEN - 1;
      q = quote_of(c);
      if (c == sqtt_pkg::CH_NUL) begin
        close_at_end(cur, last, got, r);
        tk_stopped = 1'b1;
      end else begin
        case (tk_phase)
          sqtt_pkg::PH_SKIP1, sqtt_pkg::PH_SKIP2: begin
            if (!blank_char(c)) begin
              if (tk_phase == sqtt_pkg::PH_SKIP1 && c == sqtt_pkg::CH_MINUS) begin
                tk_include = 1'b0;
                tk_phase = sqtt_pkg::PH_SKIP2;
              end else if (q != sqtt_pkg::QK_NONE) begin
                tk_quote = q;
                open_term(nidx);
              end else begin
                open_term(idx);
                term_char(c, cur, idx, last, got, r);
              end
            end
          end
          sqtt_pkg::PH_TERM: begin
            term_char(c, cur, idx, last, got, r);
          end
          sqtt_pkg::PH_COLON: begin
            if (q != sqtt_pkg::QK_NONE) begin
              tk_quote = q;
              tk_phase = sqtt_pkg::PH_QUOTE;
            end else begin
              open_term(idx);
              tk_filled = 1'b1;
            end
          end
          default: begin
            open_term(idx);
            tk_filled = 1'b1;
          end
        endcase
        if (last && !got) close_at_end(tk_pos, 1'b1, got, r);
      end
    end
    // The final byte always reports: a bare end marker when no term closed
    if (last && !got) begin
      r = '0;
      r.end_of_query = 1'b1;
      r.too_long = tk_overflow;
      got = 1'b1;
    end
    if (last) tok_reset();
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 1) == 0) return sqtt_pkg::CH_SPACE;
    return sqtt_pkg::CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return sqtt_pkg::CH_COLON;
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 25));
    do c = 8'($urandom_range(33, 255));
    while (c == sqtt_pkg::CH_COLON || c == sqtt_pkg::CH_DQUOTE || c == sqtt_pkg::CH_SQUOTE);
    return c;
  endfunction

  task automatic add_word(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) qbuf.push_back(word_char());
  endtask

  // Quoted span; blanks and colons inside, sometimes left unclosed
  task automatic add_quoted();
    logic [7:0] qc, c;
    qc = ($urandom_range(0, 1) == 0) ? sqtt_pkg::CH_SQUOTE : sqtt_pkg::CH_DQUOTE;
    qbuf.push_back(qc);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) c = rand_blank();
      else c = 8'($urandom_range(1, 255));
      if (c == qc) c = sqtt_pkg::CH_COLON;
      qbuf.push_back(c);
    end
    if ($urandom_range(0, 6) != 0) qbuf.push_back(qc);
  endtask

  task automatic add_term();
    int r;
    if ($urandom_range(0, 3) == 0) begin
      qbuf.push_back(sqtt_pkg::CH_MINUS);
      if ($urandom_range(0, 3) == 0) qbuf.push_back(rand_blank());
    end
    r = $urandom_range(0, 99);
    if (r < 35) begin
      add_word(0, 4);
      qbuf.push_back(sqtt_pkg::CH_COLON);
      case ($urandom_range(0, 3))
        0: add_quoted();
        1: begin
          qbuf.push_back(8'($urandom_range(1, 255)));
          add_word(0, 4);
        end
        2: add_word(1, 5);
        default: ;
      endcase
    end else if (r < 60) begin
      add_quoted();
    end else begin
      add_word(1, 6);
    end
  endtask

  task automatic add_terms(input int nterms, input int min_len);
    int k;
    k = 0;
    while (k < nterms || qbuf.size() < min_len) begin
      if (k > 0) repeat ($urandom_range(1, 2)) qbuf.push_back(rand_blank());
      add_term();
      k++;
    end
  endtask

  task automatic add_query();
    repeat ($urandom_range(0, 2)) qbuf.push_back(rand_blank());
    add_terms($urandom_range(0, 4), 0);
    if ($urandom_range(0, 4) == 0 || qbuf.size() == 0) qbuf.push_back(rand_blank());
  endtask

  // Move the built query into the send queue; count the bytes up to and including the first zero byte
  task automatic push_query(input logic drain, output int used);
    logic stopped;
    used = 0;
    stopped = 1'b0;
    foreach (qbuf[i]) begin
      pending.push_back('{data: qbuf[i], last: (i == qbuf.size() - 1), drain: drain && i == 0});
      if (!stopped) used++;
      if (qbuf[i] == sqtt_pkg::CH_NUL) stopped = 1'b1;
    end
    qbuf.delete();
  endtask

  // ---------------------------------------------------------------- transfers

  // Present the next byte; hold it steady until it transfers
  always @(negedge clk) begin
    byte_item_t nxt;
    if (rst_n && (!in_valid || in_xfer)) begin
      if (pending.size() != 0 && !(pending[0].drain && term_q.size() != 0) &&
          (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending.pop_front();
        in_valid <= 1'b1;
        in_query_byte <= nxt.data;
        in_last_byte <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure, with one long hold-off while bytes keep coming
  always @(negedge clk) begin
    if (!hold_done && in_count >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [LW-1:0] want,
                             input logic [LW-1:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  // Predict on each input transfer, score each result transfer
  always @(posedge clk) begin
    term_rec_t want;
    logic got;
    in_xfer = rst_n && in_valid && in_ready;
    if (in_xfer) begin
      tok_byte(in_query_byte, in_last_byte, got, want);
      if (got) term_q.push_back(want);
      in_count++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (term_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, got term_valid %0d offset %0d length %0d",
                 $time, out_term_valid, out_term_offset, out_term_length);
        errors++;
      end else begin
        want = term_q.pop_front();
        check_field("term_valid", LW'(want.term_valid), LW'(out_term_valid));
        check_field("include_term", LW'(want.include_term), LW'(out_include_term));
        check_field("has_prefix", LW'(want.has_prefix), LW'(out_has_prefix));
        check_field("prefix_offset", LW'(want.prefix_offset), LW'(out_prefix_offset));
        check_field("prefix_length", want.prefix_length, out_prefix_length);
        check_field("term_offset", LW'(want.term_offset), LW'(out_term_offset));
        check_field("term_length", want.term_length, out_term_length);
        check_field("end_of_query", LW'(want.end_of_query), LW'(out_end_of_query));
        check_field("too_long", LW'(want.too_long), LW'(out_too_long));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("search_query_term_tokenizer_core_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int used, rand_items, r;
    rand_items = 0;
    tok_reset();

    // Zero byte as the whole query
    qbuf = '{sqtt_pkg::CH_NUL};
    push_query(1'b0, used);
    // Plain term closed by the end of the query
    qbuf = '{8'h61, 8'h62};
    push_query(1'b0, used);
    // Excluded term, prefix, quote right after the colon, quote never closed
    qbuf = '{sqtt_pkg::CH_MINUS, 8'h63, sqtt_pkg::CH_COLON, sqtt_pkg::CH_DQUOTE, 8'h64};
    push_query(1'b0, used);
    // Empty single-quoted term
    qbuf = '{sqtt_pkg::CH_SQUOTE, sqtt_pkg::CH_SQUOTE};
    push_query(1'b0, used);
    // Colon at the very end leaves an empty term
    qbuf = '{8'h61, sqtt_pkg::CH_COLON};
    push_query(1'b0, used);
    // Zero byte mid-query, trailing byte ignored
    qbuf = '{8'h78, sqtt_pkg::CH_NUL, 8'h79};
    push_query(1'b0, used);
    // High byte term, then minus and a blank before the next term
    qbuf = '{8'hFF, sqtt_pkg::CH_TAB, sqtt_pkg::CH_MINUS, sqtt_pkg::CH_SPACE, 8'h7A};
    push_query(1'b0, used);
    // Second colon turns the term into the new prefix
    qbuf = '{8'h61, sqtt_pkg::CH_COLON, 8'h62, sqtt_pkg::CH_COLON, 8'h63};
    push_query(1'b0, used);

    // Random queries; the first waits for the directed results to drain
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        add_query();
      end else if (r < 88) begin
        add_query();
        qbuf[$urandom_range(0, qbuf.size() - 1)] =
          ($urandom_range(0, 1) == 0) ? sqtt_pkg::CH_NUL : 8'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 9))
            0: qbuf.push_back(sqtt_pkg::CH_NUL);
            1: qbuf.push_back(sqtt_pkg::CH_MINUS);
            2: qbuf.push_back(sqtt_pkg::CH_COLON);
            3: qbuf.push_back(sqtt_pkg::CH_DQUOTE);
            4: qbuf.push_back(sqtt_pkg::CH_SQUOTE);
            5: qbuf.push_back(rand_blank());
            default: qbuf.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      push_query(rand_items == 0, used);
      rand_items += used;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (term_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("search_query_term_tokenizer_core_tb: clean");
    else $display("search_query_term_tokenizer_core_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
hdl/sqtt_pkg.sv
hdl/search_query_term_tokenizer_core.sv
hdl/sqtt_checker.sv
sim/search_query_term_tokenizer_core_tb.sv
